>>> src/slt_pkg.sv
// shared types and constants of the session-description line tokenizer
package slt_pkg;

  localparam int POSITION_BITS = 32;
  localparam int LENGTH_BITS   = 16;
  localparam int INDEX_BITS    = 8;
  localparam int TYPE_BITS     = 8;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    EV_BEGIN = 2'd0,
    EV_TOKEN = 2'd1,
    EV_END   = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e              kind;
    logic [TYPE_BITS-1:0]     field_type;
    logic [INDEX_BITS-1:0]    index;
    logic [POSITION_BITS-1:0] start;
    logic [LENGTH_BITS-1:0]   length;
  } event_t;

  // one queue entry carries every event caused by one input item
  typedef struct packed {
    logic   two;
    event_t ev0;
    event_t ev1;
  } entry_t;

endpackage

>>> src/slt_front.sv
// front: tokenizer state, byte classification and event packing
module slt_front import slt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 func_i,
  input  logic [7:0]           data_byte_i,
  output logic                 push_o,
  output entry_t               entry_o
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [INDEX_BITS-1:0]  IDX_MAX = {INDEX_BITS{1'b1}};

  logic                     in_desc_q, in_desc_d;
  logic [7:0]               prev_q, prev_d;
  logic [TYPE_BITS-1:0]     type_q, type_d;
  logic [LENGTH_BITS-1:0]   run_q, run_d;
  logic [INDEX_BITS-1:0]    count_q, count_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     acr_q, acr_d;

  logic                     is_space, is_eq, ends_field;
  logic                     tok_emit;
  logic [INDEX_BITS-1:0]    count_after_tok;
  event_t                   tok_ev, end_ev, beg_ev;
  logic                     has_tok, has_end, has_beg;

  always_comb begin
    is_space = (data_byte_i == CH_SPACE) ||
               ((data_byte_i >= CH_TAB) && (data_byte_i <= CH_CR));
    is_eq    = (data_byte_i == CH_EQ) && !in_desc_q;
    ends_field = (data_byte_i == CH_CR) || ((data_byte_i == CH_LF) && !acr_q);
    tok_emit = in_desc_q && (run_q != '0);
    count_after_tok = (tok_emit && (count_q != IDX_MAX)) ? count_q + 1'b1 : count_q;

    tok_ev.kind       = EV_TOKEN;
    tok_ev.field_type = type_q;
    tok_ev.index      = count_q;
    tok_ev.start      = pos_q - POSITION_BITS'(run_q);
    tok_ev.length     = run_q;

    end_ev.kind       = EV_END;
    end_ev.field_type = type_q;
    end_ev.index      = count_after_tok;
    end_ev.start      = '0;
    end_ev.length     = '0;

    beg_ev.kind       = EV_BEGIN;
    beg_ev.field_type = prev_q;
    beg_ev.index      = count_q;
    beg_ev.start      = '0;
    beg_ev.length     = '0;

    has_tok = 1'b0;
    has_end = 1'b0;
    has_beg = 1'b0;

    in_desc_d = in_desc_q;
    prev_d    = prev_q;
    type_d    = type_q;
    run_d     = run_q;
    count_d   = count_q;
    pos_d     = pos_q;
    acr_d     = acr_q;

    if (func_i == FUNC_FLUSH) begin
      has_tok   = tok_emit;
      has_end   = in_desc_q;
      in_desc_d = 1'b0;
      prev_d    = '0;
      type_d    = '0;
      run_d     = '0;
      count_d   = '0;
      pos_d     = '0;
      acr_d     = 1'b0;
    end else begin
      if (is_eq) begin
        has_beg   = 1'b1;
        type_d    = prev_q;
        run_d     = '0;
        in_desc_d = 1'b1;
      end else if (is_space) begin
        has_tok = tok_emit;
        if (tok_emit) begin
          run_d   = '0;
          count_d = count_after_tok;
        end
        if (ends_field) begin
          has_end   = 1'b1;
          count_d   = '0;
          in_desc_d = 1'b0;
        end
      end else if (run_q != LEN_MAX) begin
        run_d = run_q + 1'b1;
      end
      acr_d  = (data_byte_i == CH_CR);
      prev_d = data_byte_i;
      pos_d  = pos_q + 1'b1;
    end

    // pack in emission order: begin alone, or token then field end
    entry_o.two = has_tok && has_end;
    entry_o.ev1 = end_ev;
    if (has_beg) begin
      entry_o.ev0 = beg_ev;
    end else if (has_tok) begin
      entry_o.ev0 = tok_ev;
    end else begin
      entry_o.ev0 = end_ev;
    end
    push_o = accept_i && (has_beg || has_tok || has_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_desc_q <= 1'b0;
      prev_q    <= '0;
      type_q    <= '0;
      run_q     <= '0;
      count_q   <= '0;
      pos_q     <= '0;
      acr_q     <= 1'b0;
    end else if (accept_i) begin
      in_desc_q <= in_desc_d;
      prev_q    <= prev_d;
      type_q    <= type_d;
      run_q     <= run_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      acr_q     <= acr_d;
    end
  end

  // tokens are only counted inside a description
  a_field_mode_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_desc_q |-> (count_q == '0))
    else $error("token count nonzero in field mode");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (func_i == FUNC_FLUSH)) |=> (pos_q == '0) && !in_desc_q && (run_q == '0))
    else $error("state not cleared after end of input");

endmodule

>>> src/slt_queue.sv
// short queue of event entries between front and back
module slt_queue import slt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o,
  output logic   full_o
);

  entry_t               mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_BITS'(QDEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

>>> src/slt_back.sv
// back: splits queue entries into single results in an output register
module slt_back import slt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  input  logic   q_empty_i,
  output logic   q_pop_o,
  input  logic   out_pop_i,
  output logic   out_valid_o,
  output event_t out_ev_o,
  output logic   out_last_o
);

  logic   valid_q;
  logic   sel_q;
  event_t ev_q;
  logic   last_q;

  logic   load, take, cur_last;
  event_t cur_ev;

  always_comb begin
    load     = !valid_q || out_pop_i;
    take     = load && !q_empty_i;
    cur_ev   = sel_q ? head_i.ev1 : head_i.ev0;
    cur_last = sel_q || !head_i.two;
    q_pop_o  = take && cur_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
      sel_q   <= !cur_last;
    end else if (out_pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ev_q   <= cur_ev;
      last_q <= cur_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ev_o    = ev_q;
  assign out_last_o  = last_q;

endmodule

>>> src/sdp_line_tokenizer_top.sv
// top level of the session-description line tokenizer
// takes one text byte (or an end-of-input marker) per transfer and reports
// field begin, token and field end events through a queue-style result port.
// an input transfer completes at a clock edge with push high and full low;
// a result transfer completes with pop high and empty low. every input is
// classified in the cycle it is taken, so the block sustains one input per
// cycle while full is low; an input causes zero, one or two results and the
// result port moves one per cycle while pop is high, so a stream where most
// bytes cause a result runs at that rate and a four-entry queue between
// classifier and result stage absorbs bursts. the first result passes through
// the queue and then the output register before it reaches the result ports.
// last_o marks the final result of each input. token length and index saturate,
// token start wraps with the stream offset, and end of input flushes a pending
// token and field end and then returns the tokenizer state to its reset values
module sdp_line_tokenizer_top import slt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input side
  input  logic                     push,
  output logic                     full,
  input  logic                     func_i,
  input  logic [7:0]               data_byte_i,
  // result side
  output logic                     empty,
  input  logic                     pop,
  output logic [1:0]               event_kind_o,
  output logic [TYPE_BITS-1:0]     field_type_o,
  output logic [INDEX_BITS-1:0]    token_index_o,
  output logic [POSITION_BITS-1:0] token_start_o,
  output logic [LENGTH_BITS-1:0]   token_length_o,
  output logic                     last_o
);

  logic   accept;
  logic   f_push;
  entry_t f_entry;
  entry_t q_head;
  logic   q_empty, q_full, q_pop;
  logic   out_valid, out_pop, out_last;
  event_t out_ev;

  // an input transfer happens whenever push is high and the queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  slt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .push_o      (f_push),
    .entry_o     (f_entry)
  );

  slt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .entry_i (f_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // result transfer frees the output register for the next event
  assign out_pop = pop && out_valid;

  slt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_pop_i   (out_pop),
    .out_valid_o (out_valid),
    .out_ev_o    (out_ev),
    .out_last_o  (out_last)
  );

  assign empty          = !out_valid;
  assign event_kind_o   = out_ev.kind;
  assign field_type_o   = out_ev.field_type;
  assign token_index_o  = out_ev.index;
  assign token_start_o  = out_ev.start;
  assign token_length_o = out_ev.length;
  assign last_o         = out_last;

endmodule
